@@ hw/rtl/mips_subset_decode_execute_assert.svh @@
// Assertion macros used by the top-level RTL file. Each expects clk and rst_n in scope.
`ifndef MIPS_SUBSET_DECODE_EXECUTE_ASSERT_SVH
`define MIPS_SUBSET_DECODE_EXECUTE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define MSDE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge requires the consequent at the next edge.
`define MSDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/msde_pkg.sv @@
`default_nettype none
package msde_pkg;

  localparam int REG_COUNT = 32;
  localparam int RF_AW     = $clog2(REG_COUNT);

  // Opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;

  // R-type funct codes
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_SLT = 6'h2A;

  typedef enum logic [3:0] {
    K_ADD   = 4'd0,
    K_SUB   = 4'd1,
    K_AND   = 4'd2,
    K_OR    = 4'd3,
    K_SLT   = 4'd4,
    K_ADDI  = 4'd5,
    K_ANDI  = 4'd6,
    K_ORI   = 4'd7,
    K_LUI   = 4'd8,
    K_LW    = 4'd9,
    K_SW    = 4'd10,
    K_BEQ   = 4'd11,
    K_BNE   = 4'd12,
    K_BADF  = 4'd13,
    K_BADOP = 4'd14
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              wrote;
    logic [RF_AW-1:0]  dest_index;
    logic [31:0]       dest_value;
    logic              branch_taken;
  } exec_t;

  typedef struct packed {
    logic              en;
    logic [RF_AW-1:0]  addr;
    logic [31:0]       data;
  } rf_wr_t;

endpackage
`default_nettype wire

@@ hw/rtl/msde_regfile.sv @@
`default_nettype none
module msde_regfile (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          rd_en,
  input  wire  [msde_pkg::RF_AW-1:0]   rd_addr_a,
  input  wire  [msde_pkg::RF_AW-1:0]   rd_addr_b,
  input  wire  msde_pkg::rf_wr_t       wr,
  output logic [31:0]                  rd_data_a,
  output logic [31:0]                  rd_data_b
);

  logic [31:0]                     mem [msde_pkg::REG_COUNT];
  logic [msde_pkg::REG_COUNT-1:0]  valid_r;
  logic [31:0]                     q_a_r, q_b_r;
  logic                            vld_a_r, vld_b_r;
  logic                            byp_a_r, byp_b_r;
  logic [31:0]                     byp_data_r;

  // Write port and per-entry valid bits; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // Registered read; capture a same-edge write as a bypass.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a_r <= mem[rd_addr_a];
      q_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else if (rd_en) begin
      vld_a_r <= valid_r[rd_addr_a];
      vld_b_r <= valid_r[rd_addr_b];
      byp_a_r <= wr.en && (wr.addr == rd_addr_a);
      byp_b_r <= wr.en && (wr.addr == rd_addr_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r <= wr.data;
    end
  end

  assign rd_data_a = byp_a_r ? byp_data_r : (vld_a_r ? q_a_r : 32'd0);
  assign rd_data_b = byp_b_r ? byp_data_r : (vld_b_r ? q_b_r : 32'd0);

endmodule
`default_nettype wire

@@ hw/rtl/msde_exec.sv @@
`default_nettype none
module msde_exec (
  input  wire  [31:0]           instr,
  input  wire  [31:0]           op_a,
  input  wire  [31:0]           op_b,
  output msde_pkg::exec_t       res
);

  logic [5:0]                   opcode, funct;
  logic [msde_pkg::RF_AW-1:0]   rt, rd;
  logic [15:0]                  imm;
  logic [31:0]                  simm, zimm;
  msde_pkg::kind_t              kind;
  logic                         wr, taken;
  logic [msde_pkg::RF_AW-1:0]   dst;
  logic [31:0]                  val;

  assign opcode = instr[31:26];
  assign rt     = instr[20:16];
  assign rd     = instr[15:11];
  assign funct  = instr[5:0];
  assign imm    = instr[15:0];
  assign simm   = {{16{imm[15]}}, imm};
  assign zimm   = {16'd0, imm};

  always_comb begin
    kind  = msde_pkg::K_BADOP;
    wr    = 1'b0;
    taken = 1'b0;
    val   = 32'd0;
    dst   = rt;
    unique case (opcode)
      msde_pkg::OP_RTYPE: begin
        dst = rd;
        wr  = 1'b1;
        unique case (funct)
          msde_pkg::FN_ADD: begin kind = msde_pkg::K_ADD; val = op_a + op_b; end
          msde_pkg::FN_SUB: begin kind = msde_pkg::K_SUB; val = op_a - op_b; end
          msde_pkg::FN_AND: begin kind = msde_pkg::K_AND; val = op_a & op_b; end
          msde_pkg::FN_OR:  begin kind = msde_pkg::K_OR;  val = op_a | op_b; end
          msde_pkg::FN_SLT: begin
            kind = msde_pkg::K_SLT;
            val  = {31'd0, $signed(op_a) < $signed(op_b)};
          end
          default: begin kind = msde_pkg::K_BADF; wr = 1'b0; end
        endcase
      end
      msde_pkg::OP_ADDI: begin kind = msde_pkg::K_ADDI; wr = 1'b1; val = op_a + simm; end
      msde_pkg::OP_ANDI: begin kind = msde_pkg::K_ANDI; wr = 1'b1; val = op_a & zimm; end
      msde_pkg::OP_ORI:  begin kind = msde_pkg::K_ORI;  wr = 1'b1; val = op_a | zimm; end
      msde_pkg::OP_LUI:  begin kind = msde_pkg::K_LUI;  wr = 1'b1; val = {imm, 16'd0}; end
      msde_pkg::OP_LW:   kind = msde_pkg::K_LW;
      msde_pkg::OP_SW:   kind = msde_pkg::K_SW;
      msde_pkg::OP_BEQ:  begin kind = msde_pkg::K_BEQ; taken = (op_a == op_b); end
      msde_pkg::OP_BNE:  begin kind = msde_pkg::K_BNE; taken = (op_a != op_b); end
      default:           kind = msde_pkg::K_BADOP;
    endcase

    // Drop writes that do not happen or that target register zero.
    res.kind         = kind;
    res.branch_taken = taken;
    if (wr && (dst != '0)) begin
      res.wrote      = 1'b1;
      res.dest_index = dst;
      res.dest_value = val;
    end else begin
      res.wrote      = 1'b0;
      res.dest_index = '0;
      res.dest_value = 32'd0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mips_subset_decode_execute.sv @@
// Flow: an accepted transaction is registered in execute, then in the output register.
// Throughput: one instruction per cycle unless the output stalls; the register file
// has two read ports and one write port; a write at the edge of a read is bypassed into it.
// Reset (rst_n low, synchronous) empties the pipeline and clears the register
// file's per-entry valid bits at once, so every register reads as zero; there is
// no clearing pass, and an input transaction may be accepted right after reset.
`default_nettype none
`include "mips_subset_decode_execute_assert.svh"
module mips_subset_decode_execute (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [31:0]         in_instr_word,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [3:0]          out_kind,
  output logic                out_wrote,
  output logic [4:0]          out_dest_index,
  output logic signed [31:0]  out_dest_value,
  output logic                out_branch_taken
);

  // Pipeline:
  //   accept  - the transaction's rs and rt go to the register file read ports
  //   execute - read data is back; decode and execute, write back on advance
  //   output  - result register holds the transaction until out_ready
  logic              in_fire;
  logic              s1_vld_r, s1_vld_nxt;
  logic [31:0]       s1_instr_r;
  logic              s1_adv;
  logic              out_vld_r, out_vld_nxt;
  msde_pkg::exec_t   out_res_r;
  msde_pkg::exec_t   ex_res;
  msde_pkg::rf_wr_t  rf_wr;
  logic [31:0]       rf_a, rf_b;
  logic              out_stalled, out_taken, out_is_branch;

  // Execute stage advances whenever the output register is empty or draining.
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // Register file write happens at the edge where the instruction leaves execute.
  assign rf_wr.en   = s1_adv && ex_res.wrote;
  assign rf_wr.addr = ex_res.dest_index;
  assign rf_wr.data = ex_res.dest_value;

  msde_regfile u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (in_instr_word[25:21]),
    .rd_addr_b (in_instr_word[20:16]),
    .wr        (rf_wr),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b)
  );

  msde_exec u_exec (
    .instr (s1_instr_r),
    .op_a  (rf_a),
    .op_b  (rf_b),
    .res   (ex_res)
  );

  always_comb begin
    s1_vld_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: capture the instruction on accept and the result when execute advances, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr_r <= in_instr_word;
    end
    if (s1_adv) begin
      out_res_r <= ex_res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_res_r.kind;
  assign out_wrote        = out_res_r.wrote;
  assign out_dest_index   = out_res_r.dest_index;
  assign out_dest_value   = $signed(out_res_r.dest_value);
  assign out_branch_taken = out_res_r.branch_taken;

  assign out_stalled   = out_vld_r && !out_ready;
  assign out_taken     = out_vld_r && out_res_r.branch_taken;
  assign out_is_branch = (out_res_r.kind == msde_pkg::K_BEQ) ||
                         (out_res_r.kind == msde_pkg::K_BNE);

  // Register zero is never written.
  `MSDE_ASSERT_ALWAYS(a_no_r0_write, !rf_wr.en || (rf_wr.addr != '0), "write to register zero")
  // Input stalls only when execute is full and cannot drain.
  `MSDE_ASSERT_ALWAYS(a_stall_cause, in_ready || (s1_vld_r && out_stalled), "spurious input stall")
  // An accepted transaction occupies execute in the next cycle.
  `MSDE_ASSERT_NEXT(a_accept_fill, in_fire, s1_vld_r, "accepted transaction lost")
  // A branch outcome only comes with a branch kind.
  `MSDE_ASSERT_ALWAYS(a_taken_kind, !out_taken || out_is_branch, "branch_taken on non-branch")

endmodule
`default_nettype wire
